>>> rtl/psdf_pkg.sv
// shared types and constants for the preamble sync byte-pair deframer
`default_nettype none
package psdf_pkg;

  localparam int WIN_BYTES = 8;              // preamble length in bytes
  localparam int CELLS     = WIN_BYTES - 1;  // stored window bytes, newest byte arrives live
  localparam int PAT_W     = 8 * WIN_BYTES;

  localparam logic [1:0] EV_INFO = 2'd0;
  localparam logic [1:0] EV_CONN = 2'd1;
  localparam logic [1:0] EV_MSG  = 2'd2;

  typedef enum logic [2:0] {
    MODE_HUNT = 3'b001,
    MODE_INFO = 3'b010,
    MODE_CONN = 3'b100
  } link_mode_t;

  // window row to controller
  typedef struct packed {
    logic       full;     // incoming byte completes an 8-byte window
    logic       match;    // completed window equals the preamble
    logic [7:0] leaving;  // oldest byte, leaves on a miss
  } win_stat_t;

  // controller to window row
  typedef struct packed {
    logic shift;
    logic clear;
  } win_ctl_t;

endpackage
`default_nettype wire

>>> rtl/preamble_sync_byte_pair_deframer_top.sv
// top level of the preamble sync byte-pair deframer
//
// Input channel: rx_byte with in_valid / in_ready, one received byte per transfer.
// Output channel: event_kind, info_byte, element_code, message_value with
// out_valid / out_ready; zero or one result per input byte.
// Configuration: cfg_write loads cfg_data into the 64-bit preamble register
// (first received byte in bits 63..56); it is used from the next cycle on.
// Hunt mode drops bytes until the preamble is seen, info mode then emits each
// byte leaving the window as an info event, a second preamble gives one
// connected event, after which every byte pair gives an element message.
// Throughput: one byte per cycle while in_ready is high. The window is a row of
// seven byte cells that shift on each transfer in hunt and info modes while the
// newest byte is compared live. A result is written to the output register on
// its input transfer. in_ready is high while the output register is empty or
// being taken, so a stall on the output holds at most one result and then stops
// input until the receiver takes it.
// Reset: synchronous rst returns to hunt mode with an empty window, clears
// out_valid and the preamble (pattern zero).
`default_nettype none
module preamble_sync_byte_pair_deframer_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [1:0]  event_kind,
  output logic      [7:0]  info_byte,
  output logic      [7:0]  element_code,
  output logic      [7:0]  message_value
);
  import psdf_pkg::*;

  logic [PAT_W-1:0] sync_pattern;
  logic [7:0]       cell_byte  [CELLS];
  logic [CELLS-1:0] cell_valid;
  logic [CELLS-1:0] cell_hit;
  win_stat_t        win_stat;
  win_ctl_t         win_ctl;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_pattern <= '0;
    end else if (cfg_write) begin
      sync_pattern <= cfg_data;
    end
  end

  // cell i holds window position i+1, position 0 is the incoming byte
  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    if (i == 0) begin : g_first
      psdf_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .shift      (win_ctl.shift),
        .clear      (win_ctl.clear),
        .din        (rx_byte),
        .din_valid  (1'b1),
        .pat_byte   (sync_pattern[8*(i+1) +: 8]),
        .dout       (cell_byte[i]),
        .dout_valid (cell_valid[i]),
        .hit        (cell_hit[i])
      );
    end else begin : g_rest
      psdf_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .shift      (win_ctl.shift),
        .clear      (win_ctl.clear),
        .din        (cell_byte[i-1]),
        .din_valid  (cell_valid[i-1]),
        .pat_byte   (sync_pattern[8*(i+1) +: 8]),
        .dout       (cell_byte[i]),
        .dout_valid (cell_valid[i]),
        .hit        (cell_hit[i])
      );
    end
  end

  // the row fills from the newest end, so the last cell valid means full
  assign win_stat.full    = cell_valid[CELLS-1];
  assign win_stat.match   = (rx_byte == sync_pattern[7:0]) && (&cell_hit);
  assign win_stat.leaving = cell_byte[CELLS-1];

  psdf_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .rx_byte       (rx_byte),
    .win_stat      (win_stat),
    .win_ctl       (win_ctl),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .event_kind    (event_kind),
    .info_byte     (info_byte),
    .element_code  (element_code),
    .message_value (message_value)
  );

endmodule
`default_nettype wire

>>> rtl/psdf_cell.sv
// one byte cell of the sliding preamble window
`default_nettype none
module psdf_cell (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       shift,
  input  wire logic       clear,
  input  wire logic [7:0] din,
  input  wire logic       din_valid,
  input  wire logic [7:0] pat_byte,
  output logic      [7:0] dout,
  output logic            dout_valid,
  output logic            hit
);

  logic [7:0] data;
  logic       valid;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= din_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      data <= din;
    end
  end

  assign dout       = data;
  assign dout_valid = valid;
  assign hit        = (data == pat_byte);

endmodule
`default_nettype wire

>>> rtl/psdf_ctrl.sv
// mode control, byte pairing and output register of the deframer
`default_nettype none
module psdf_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [7:0]          rx_byte,
  input  wire psdf_pkg::win_stat_t win_stat,
  output psdf_pkg::win_ctl_t       win_ctl,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic      [1:0]          event_kind,
  output logic      [7:0]          info_byte,
  output logic      [7:0]          element_code,
  output logic      [7:0]          message_value
);
  import psdf_pkg::*;

  link_mode_t mode, mode_next;
  logic       pair_pending, pair_pending_next;
  logic [7:0] held_byte, held_byte_next;
  logic       accept;
  logic       res_valid;
  logic [1:0] res_kind;
  logic [7:0] res_info, res_code, res_value;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    mode_next         = mode;
    pair_pending_next = pair_pending;
    held_byte_next    = held_byte;
    res_valid         = 1'b0;
    res_kind          = EV_INFO;
    res_info          = 8'd0;
    res_code          = 8'd0;
    res_value         = 8'd0;
    win_ctl.shift     = 1'b0;
    win_ctl.clear     = 1'b0;
    if (accept) begin
      case (mode)
        MODE_CONN: begin
          if (pair_pending) begin
            res_valid         = 1'b1;
            res_kind          = EV_MSG;
            res_code          = held_byte;
            res_value         = rx_byte;
            pair_pending_next = 1'b0;
          end else begin
            held_byte_next    = rx_byte;
            pair_pending_next = 1'b1;
          end
        end
        MODE_INFO: begin
          win_ctl.shift = 1'b1;
          win_ctl.clear = win_stat.full && win_stat.match;
          if (win_stat.full) begin
            res_valid = 1'b1;
            if (win_stat.match) begin
              res_kind          = EV_CONN;
              mode_next         = MODE_CONN;
              pair_pending_next = 1'b0;
            end else begin
              res_kind = EV_INFO;
              res_info = win_stat.leaving;
            end
          end
        end
        default: begin
          win_ctl.shift = 1'b1;
          win_ctl.clear = win_stat.full && win_stat.match;
          if (win_stat.full && win_stat.match) begin
            mode_next = MODE_INFO;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_HUNT;
      pair_pending <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      mode         <= mode_next;
      pair_pending <= pair_pending_next;
      if (accept) begin
        out_valid <= res_valid;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    held_byte <= held_byte_next;
    if (accept && res_valid) begin
      event_kind    <= res_kind;
      info_byte     <= res_info;
      element_code  <= res_code;
      message_value <= res_value;
    end
  end

  a_conn_sticky: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_CONN |=> mode == MODE_CONN)
    else $error("connected mode left without reset");

  a_pending_only_conn: assert property (@(posedge clk) disable iff (rst)
    pair_pending |-> mode == MODE_CONN)
    else $error("pair held outside connected mode");

  a_hunt_silent: assert property (@(posedge clk) disable iff (rst)
    accept && mode == MODE_HUNT |=> !out_valid)
    else $error("result produced while hunting");

  a_msg_after_conn: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_kind == EV_MSG || event_kind == EV_CONN) |-> mode == MODE_CONN)
    else $error("connect or message event outside connected mode");

endmodule
`default_nettype wire
